>>> hw/rtl/sct_pkg.sv
// ============================================================================
// sct_pkg
// Shared types, constants and microcode for the sine/cosine series unit.
// ============================================================================
`default_nettype none

package sct_pkg;

    // default configuration
    localparam int FRAC_BITS_DEF = 16;
    localparam int NUM_TERMS_DEF = 6;

    // guard bits carried below the output fraction in every term
    localparam int GUARD = 4;

    // 2*pi with 32 fraction bits
    localparam logic [63:0] TWO_PI_Q32 = 64'd26986075409;

    // field widths of the stream items
    localparam int ANGLE_W = 24;
    localparam int VALUE_W = 24;

    // microcode address width and step addresses
    localparam int PC_W = 4;
    localparam logic [PC_W-1:0] A_RED   = 4'd0;
    localparam logic [PC_W-1:0] A_INIT  = 4'd1;
    localparam logic [PC_W-1:0] A_MULMX = 4'd2;
    localparam logic [PC_W-1:0] A_RNDP  = 4'd3;
    localparam logic [PC_W-1:0] A_MULPX = 4'd4;
    localparam logic [PC_W-1:0] A_TRUNC = 4'd5;
    localparam logic [PC_W-1:0] A_MULTR = 4'd6;
    localparam logic [PC_W-1:0] A_EST   = 4'd7;
    localparam logic [PC_W-1:0] A_REM   = 4'd8;
    localparam logic [PC_W-1:0] A_ACC   = 4'd9;
    localparam logic [PC_W-1:0] A_FIN   = 4'd10;

    // datapath operations
    typedef enum logic [3:0] {
        OP_RED,     // one restoring step of the 2*pi reduction
        OP_INIT,    // finish reduction, load first term
        OP_MULMX,   // product = term * x
        OP_RNDP,    // p = rounded product
        OP_MULPX,   // product = p * x
        OP_TRUNC,   // t = rounded product, scaled down
        OP_MULTR,   // product = t * reciprocal of divisor
        OP_EST,     // quotient estimate from product high half
        OP_REM,     // remainder of the estimate
        OP_ACC,     // corrected quotient becomes next term, accumulate
        OP_FIN      // round, sign, saturate, load output register
    } t_op;

    // jump conditions
    typedef enum logic [1:0] {
        JC_NONE,     // fall through
        JC_CNT_NZ,   // jump while the step counter is nonzero
        JC_MORE,     // jump while more than one term remains
        JC_ONE_TERM  // jump when the series has a single term
    } t_jc;

    // one control word
    typedef struct packed {
        t_op             op;
        t_jc             jc;
        logic [PC_W-1:0] target;
    } t_uword;

    // status from the datapath to the sequencer
    typedef struct packed {
        logic cnt_nz;
        logic more;
        logic one_term;
        logic out_stall;
    } t_cond;

    function automatic t_uword f_uw(t_op op, t_jc jc, logic [PC_W-1:0] target);
        t_uword w;
        w.op     = op;
        w.jc     = jc;
        w.target = target;
        return w;
    endfunction

    // program: reduction loop, setup, eight-step term loop, finish
    function automatic t_uword f_ucode(logic [PC_W-1:0] addr);
        t_uword w;
        unique case (addr)
            A_RED:   w = f_uw(OP_RED,   JC_CNT_NZ,   A_RED);
            A_INIT:  w = f_uw(OP_INIT,  JC_ONE_TERM, A_FIN);
            A_MULMX: w = f_uw(OP_MULMX, JC_NONE,     A_MULMX);
            A_RNDP:  w = f_uw(OP_RNDP,  JC_NONE,     A_RNDP);
            A_MULPX: w = f_uw(OP_MULPX, JC_NONE,     A_MULPX);
            A_TRUNC: w = f_uw(OP_TRUNC, JC_NONE,     A_TRUNC);
            A_MULTR: w = f_uw(OP_MULTR, JC_NONE,     A_MULTR);
            A_EST:   w = f_uw(OP_EST,   JC_NONE,     A_EST);
            A_REM:   w = f_uw(OP_REM,   JC_NONE,     A_REM);
            A_ACC:   w = f_uw(OP_ACC,   JC_MORE,     A_MULMX);
            A_FIN:   w = f_uw(OP_FIN,   JC_NONE,     A_FIN);
            default: w = f_uw(OP_FIN,   JC_NONE,     A_FIN);
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/sct_seq.sv
// ============================================================================
// sct_seq
// Microcode sequencer: step counter, control store and conditional jumps.
// ============================================================================
`default_nettype none

module sct_seq
    import sct_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_start,
    input  wire t_cond  i_cond,
    output t_uword      o_uw,
    output logic        o_busy
);

    logic [PC_W-1:0] r_pc;
    logic            r_busy;
    t_uword          w_uw;
    logic            w_jump;

    // control store lookup and jump decision
    always_comb begin
        w_uw = f_ucode(r_pc);
        unique case (w_uw.jc)
            JC_NONE:     w_jump = 1'b0;
            JC_CNT_NZ:   w_jump = i_cond.cnt_nz;
            JC_MORE:     w_jump = i_cond.more;
            JC_ONE_TERM: w_jump = i_cond.one_term;
            default:     w_jump = 1'b0;
        endcase
    end

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pc   <= A_RED;
        end else if (!r_busy) begin
            if (i_start) begin
                r_busy <= 1'b1;
                r_pc   <= A_RED;
            end
        end else if (w_uw.op == OP_FIN) begin
            if (!i_cond.out_stall) begin
                r_busy <= 1'b0;
                r_pc   <= A_RED;
            end
        end else if (w_jump) begin
            r_pc <= w_uw.target;
        end else begin
            r_pc <= r_pc + 1'b1;
        end
    end

    assign o_uw   = w_uw;
    assign o_busy = r_busy;

    // program counter never leaves the program
    a_pc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_pc <= A_FIN))
        else $error("sequencer ran past the program");

    // a stalled finish step holds its place
    a_fin_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && w_uw.op == OP_FIN && i_cond.out_stall) |=> (r_busy && r_pc == A_FIN))
        else $error("finish step left while output stalled");

    // idle sequencer always restarts at the first step
    a_idle_pc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (r_pc == A_RED))
        else $error("idle sequencer not parked at start");

endmodule

`default_nettype wire

>>> hw/rtl/sine_cosine_taylor_series.sv
// ============================================================================
// sine_cosine_taylor_series
// Six-term Taylor-series sine / cosine with 2*pi range reduction.
// ============================================================================
// One request carries a signed Q8.16 angle in tdata and the function select in
// tuser (0 sine, 1 cosine). The angle magnitude is reduced into [0, 2*pi] by a
// restoring subtract loop of (21 - FRAC_BITS + 1) steps (6 at the defaults),
// then NUM_TERMS series terms are built one after the other on a single shared
// multiplier, each term after the first taking eight microcode steps (two
// multiplies by x, one multiply by a divisor reciprocal, rounding and a
// one-step quotient fix-up). An item passes through the reduction steps, the
// setup step, the term loop and the finish step, and one item is in work at a
// time. The result, signed Q8.16 in tdata with the saturation flag in tuser,
// sits in an output register, so a new request is taken while a result still
// waits to be read.
// ============================================================================
`default_nettype none

module sine_cosine_taylor_series
    import sct_pkg::*;
#(
    parameter int NUM_TERMS = NUM_TERMS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // request stream
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [23:0] i_s_tdata,   // [23:0] angle
    input  wire logic        i_s_tuser,   // [0] cmd
    // result stream
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [23:0]      o_m_tdata,   // [23:0] value
    output logic             o_m_tuser    // [0] saturated
);

    // widths derived from the fraction size and term count
    localparam int F       = FRAC_BITS;
    localparam int XW      = (F + 3 < ANGLE_W) ? F + 3 : ANGLE_W;
    localparam int MW      = F + GUARD + 8;
    localparam int PW      = MW + 3;
    localparam int TW      = PW + XW - F + 1;
    localparam int PRW     = 2 * TW;
    localparam int AW      = MW + 3;
    localparam int MGW     = AW + 1 - GUARD;
    localparam int NP      = 2 * NUM_TERMS;
    localparam int NW      = $clog2(NP);
    localparam int DW      = $clog2(NP * (NP + 1) + 1);
    localparam int JMAX    = (F < 21) ? 21 - F : 0;
    localparam int CNT_MAX = (JMAX > NUM_TERMS - 1) ? JMAX : NUM_TERMS - 1;
    localparam int CTW     = $clog2(CNT_MAX + 2);
    localparam int CW      = ANGLE_W + 2;
    localparam logic [63:0] TP = (TWO_PI_Q32 + (64'd1 << (31 - F))) >> (32 - F);

    // sequencer interface
    t_uword w_uw;
    t_cond  w_cond;
    logic   w_busy;
    logic   w_accept;

    // datapath registers
    logic                r_cmd;
    logic                r_neg_in;
    logic                r_xz;
    logic [ANGLE_W-1:0]  r_y;
    logic [XW-1:0]       r_x;
    logic [CTW-1:0]      r_cnt;
    logic [MW-1:0]       r_m;
    logic [PW-1:0]       r_p;
    logic [PRW-1:0]      r_prod;
    logic [TW-1:0]       r_t;
    logic [TW-1:0]       r_q;
    logic [TW-1:0]       r_rem;
    logic signed [AW-1:0] r_acc;
    logic                r_sub;
    logic [NW-1:0]       r_pow;
    logic                r_m_tvalid;
    logic [VALUE_W-1:0]  r_m_tdata;
    logic                r_m_tuser;

    // divisor and reciprocal tables indexed by the previous power
    logic [TW-1:0] w_rcp [NP];
    logic [DW-1:0] w_dv  [NP];

    for (genvar n = 0; n < NP; n++) begin : g_rcp
        localparam logic [63:0] DV = 64'((n + 1) * (n + 2));
        localparam logic [63:0] RV = (64'd1 << TW) / DV;
        assign w_rcp[n] = RV[TW-1:0];
        assign w_dv[n]  = DV[DW-1:0];
    end

    // combinational helpers
    logic [ANGLE_W-1:0] w_mag_in;
    logic [CW-1:0]      w_tp_sh;
    logic               w_red_sub;
    logic [XW-1:0]      w_x_red;
    logic [DW-1:0]      w_d;
    logic [TW-1:0]      w_r;
    logic [TW-1:0]      w_mul_a;
    logic [TW-1:0]      w_mul_b;
    logic [PRW-1:0]     w_rnd;
    logic [PRW-1:0]     w_trc;
    logic [TW+DW-1:0]   w_qd;
    logic [MW-1:0]      w_m_new;
    logic [AW-1:0]      w_abs;
    logic [MGW-1:0]     w_mag;
    logic [AW:0]        w_abs_rnd;
    logic               w_neg_out;
    logic [VALUE_W-1:0] w_val;
    logic               w_sat;
    logic               w_act;
    logic               w_fin_go;

    // handshake, no request taken while in reset
    assign o_s_tready = i_rst_n && !w_busy;
    assign w_accept   = i_s_tvalid && o_s_tready;

    assign w_cond.cnt_nz    = (r_cnt != '0);
    assign w_cond.more      = (r_cnt > CTW'(1));
    assign w_cond.one_term  = (NUM_TERMS == 1);
    assign w_cond.out_stall = r_m_tvalid && !i_m_tready;

    assign w_act    = w_busy && (w_uw.op != OP_FIN);
    assign w_fin_go = w_busy && (w_uw.op == OP_FIN) && !w_cond.out_stall;

    sct_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept),
        .i_cond  (w_cond),
        .o_uw    (w_uw),
        .o_busy  (w_busy)
    );

    // angle magnitude, reduction step, divisor lookup
    always_comb begin
        w_mag_in  = i_s_tdata[ANGLE_W-1] ? (~i_s_tdata + 1'b1) : i_s_tdata;
        w_tp_sh   = CW'(TP) << r_cnt;
        w_red_sub = !r_xz && ({2'b00, r_y} >= w_tp_sh);
        w_x_red   = r_xz ? '0 : XW'(r_y + 1'b1);
        w_d       = w_dv[r_pow];
        w_r       = w_rcp[r_pow];
    end

    // shared multiplier operand select
    always_comb begin
        case (w_uw.op)
            OP_MULPX: begin
                w_mul_a = TW'(r_p);
                w_mul_b = TW'(r_x);
            end
            OP_MULTR: begin
                w_mul_a = r_t;
                w_mul_b = w_r;
            end
            default: begin
                w_mul_a = TW'(r_m);
                w_mul_b = TW'(r_x);
            end
        endcase
    end

    // rounding, quotient fix-up and next term
    always_comb begin
        w_rnd   = r_prod + (PRW'(1) << (F - 1));
        w_trc   = r_prod + (PRW'(w_d) << (F - 1));
        w_qd    = r_q * w_d;
        w_m_new = r_q[MW-1:0] + MW'(r_rem >= TW'(w_d));
    end

    // final rounding, sign and saturation
    always_comb begin
        w_abs     = r_acc[AW-1] ? AW'(-r_acc) : AW'(r_acc);
        w_abs_rnd = {1'b0, w_abs} + (AW + 1)'(1 << (GUARD - 1));
        w_mag     = w_abs_rnd[AW:GUARD];
        w_neg_out = (r_acc[AW-1] ^ (!r_cmd && r_neg_in)) && (w_mag != '0);
        w_sat     = 1'b0;
        if (w_neg_out) begin
            if (64'(w_mag) > 64'h80_0000) begin
                w_sat = 1'b1;
                w_val = 24'h80_0000;
            end else begin
                w_val = VALUE_W'(-64'(w_mag));
            end
        end else begin
            if (64'(w_mag) > 64'h7F_FFFF) begin
                w_sat = 1'b1;
                w_val = 24'h7F_FFFF;
            end else begin
                w_val = VALUE_W'(w_mag);
            end
        end
    end

    // request capture and microcoded datapath
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd    <= i_s_tuser;
            r_neg_in <= i_s_tdata[ANGLE_W-1];
            r_xz     <= (w_mag_in == '0);
            r_y      <= w_mag_in - 1'b1;
            r_cnt    <= CTW'(JMAX);
        end else if (w_act) begin
            case (w_uw.op)
                OP_RED: begin
                    if (w_red_sub) begin
                        r_y <= r_y - w_tp_sh[ANGLE_W-1:0];
                    end
                    if (r_cnt != '0) begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                OP_INIT: begin
                    r_x   <= w_x_red;
                    r_cnt <= CTW'(NUM_TERMS - 1);
                    r_sub <= 1'b1;
                    if (r_cmd) begin
                        r_m   <= MW'(1) << (F + GUARD);
                        r_acc <= AW'(1) << (F + GUARD);
                        r_pow <= '0;
                    end else begin
                        r_m   <= MW'(w_x_red) << GUARD;
                        r_acc <= AW'(w_x_red) << GUARD;
                        r_pow <= NW'(1);
                    end
                end
                OP_MULMX, OP_MULPX, OP_MULTR: begin
                    r_prod <= w_mul_a * w_mul_b;
                end
                OP_RNDP: begin
                    r_p <= w_rnd[F +: PW];
                end
                OP_TRUNC: begin
                    r_t <= w_trc[F +: TW];
                end
                OP_EST: begin
                    r_q <= r_prod[PRW-1:TW];
                end
                OP_REM: begin
                    r_rem <= r_t - w_qd[TW-1:0];
                end
                OP_ACC: begin
                    r_m   <= w_m_new;
                    r_acc <= r_sub ? (r_acc - $signed({{(AW-MW){1'b0}}, w_m_new}))
                                   : (r_acc + $signed({{(AW-MW){1'b0}}, w_m_new}));
                    r_sub <= !r_sub;
                    r_pow <= r_pow + NW'(2);
                    r_cnt <= r_cnt - 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (w_fin_go) begin
            r_m_tvalid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_tvalid <= 1'b0;
        end
        if (w_fin_go) begin
            r_m_tdata <= w_val;
            r_m_tuser <= w_sat;
        end
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;
    assign o_m_tuser  = r_m_tuser;

    // reduced angle never exceeds 2*pi
    a_red_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_busy && w_uw.op == OP_INIT) |-> (64'(w_x_red) <= TP))
        else $error("range reduction left angle above 2*pi");

    // reciprocal estimate is off by at most one divisor
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_busy && w_uw.op == OP_ACC) |-> (64'(r_rem) < 64'(2 * w_d)))
        else $error("quotient estimate out of correction range");

    // a finished result always shows up on the output
    a_fin_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fin_go |=> r_m_tvalid)
        else $error("finished result not presented");

endmodule

`default_nettype wire
